[design/hmm_scaled_forward_step_unit_defines.svh]
// Assertion macros used by the top design file.
`ifndef HMM_SCALED_FORWARD_STEP_UNIT_DEFINES_SVH
`define HMM_SCALED_FORWARD_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSF_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("hsf: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("hsf: assertion failed");

`endif

[design/hsf_pkg.sv]
package hsf_pkg;

	// Fixed formats and sizes.
	localparam int MAX_STATES     = 4;
	localparam int PROB_FRAC_BITS = 15;
	localparam int PW             = 16;
	localparam int TW             = 33;
	localparam int PRODW          = 49;
	localparam int UW             = 48;
	localparam int SW             = 50;
	localparam int LNW            = 24;
	localparam int OW             = 48;
	localparam int REGW           = 64;
	localparam int FRACW          = 20;
	localparam int MANTW          = 31;

	localparam logic [PW-1:0]        ONE_P    = PW'(1) << PROB_FRAC_BITS;
	localparam logic [31:0]          LN2_Q32  = 32'd2977044472;
	localparam logic signed [OW-1:0] LOG_MIN  = {1'b1, {(OW-1){1'b0}}};
	localparam logic [5:0]           F_SUM    = 6'(3 * PROB_FRAC_BITS);
	localparam logic [5:0]           F_ALPHA  = 6'(PROB_FRAC_BITS);

	// Configuration register indexes.
	localparam logic [2:0] CFG_NUM_STATES = 3'd0;
	localparam logic [2:0] CFG_INIT_DIST  = 3'd1;
	localparam logic [2:0] CFG_TRANS_ROW0 = 3'd2;
	localparam logic [2:0] CFG_TRANS_ROW1 = 3'd3;
	localparam logic [2:0] CFG_TRANS_ROW2 = 3'd4;
	localparam logic [2:0] CFG_TRANS_ROW3 = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LANE,
		ST_MUL_A,
		ST_ADD,
		ST_MUL_E,
		ST_STORE,
		ST_CHECK,
		ST_LOG_S,
		ST_WAIT_S,
		ST_DLANE,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_ALPHA,
		ST_LOG_A,
		ST_WAIT_A,
		ST_OUT
	} hsf_state_t;

	typedef enum logic [2:0] {
		LG_IDLE,
		LG_NORM,
		LG_SQ,
		LG_MUL,
		LG_RND
	} hsf_lg_state_t;

	// Request to and response from the log unit.
	typedef struct packed {
		logic          start;
		logic [SW-1:0] x;
		logic [5:0]    f;
	} lg_req_t;

	typedef struct packed {
		logic                  done;
		logic signed [LNW-1:0] ln;
	} lg_rsp_t;

	function automatic logic [PW-1:0] clamp_prob(input logic [PW-1:0] v);
		return (v > ONE_P) ? ONE_P : v;
	endfunction

	function automatic logic [PW-1:0] lane_of(input logic [REGW-1:0] r, input logic [1:0] i);
		logic [PW-1:0] v;
		case (i)
			2'd0:    v = r[15:0];
			2'd1:    v = r[31:16];
			2'd2:    v = r[47:32];
			default: v = r[63:48];
		endcase
		return clamp_prob(v);
	endfunction

	function automatic logic signed [OW-1:0] sat48(input logic signed [OW:0] v);
		logic signed [OW-1:0] r;
		if (v[OW] != v[OW-1]) begin
			r = v[OW] ? LOG_MIN : {1'b0, {(OW-1){1'b1}}};
		end else begin
			r = v[OW-1:0];
		end
		return r;
	endfunction

endpackage

[design/hsf_step_if.sv]
interface hsf_step_if;
	import hsf_pkg::*;

	logic          valid;
	logic          ready;
	logic          seq_start;
	logic [PW-1:0] emis_0;
	logic [PW-1:0] emis_1;
	logic [PW-1:0] emis_2;
	logic [PW-1:0] emis_3;

	modport source (output valid, seq_start, emis_0, emis_1, emis_2, emis_3, input ready);
	modport sink (input valid, seq_start, emis_0, emis_1, emis_2, emis_3, output ready);
endinterface

[design/hsf_result_if.sv]
interface hsf_result_if;
	import hsf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [PW-1:0]        alpha_0;
	logic [PW-1:0]        alpha_1;
	logic [PW-1:0]        alpha_2;
	logic [PW-1:0]        alpha_3;
	logic signed [OW-1:0] log_alpha_0;
	logic signed [OW-1:0] log_alpha_1;
	logic signed [OW-1:0] log_alpha_2;
	logic signed [OW-1:0] log_alpha_3;
	logic                 zero_sum_error;

	modport source (output valid, alpha_0, alpha_1, alpha_2, alpha_3, log_alpha_0,
		log_alpha_1, log_alpha_2, log_alpha_3, zero_sum_error, input ready);
	modport sink (input valid, alpha_0, alpha_1, alpha_2, alpha_3, log_alpha_0,
		log_alpha_1, log_alpha_2, log_alpha_3, zero_sum_error, output ready);
endinterface

[design/hsf_log.sv]
module hsf_log (
	input  logic             clk,
	input  logic             arst_n,
	input  hsf_pkg::lg_req_t req,
	output hsf_pkg::lg_rsp_t rsp
);
	import hsf_pkg::*;

	hsf_lg_state_t       state_q, state_d;
	logic [SW-1:0]       n_q;
	logic [5:0]          p_q;
	logic [5:0]          f_q;
	logic [MANTW-1:0]    m_q;
	logic [FRACW-1:0]    frac_q;
	logic [4:0]          b_q;
	logic [57:0]         prod_q;
	logic                neg_q;

	logic [2*MANTW-1:0]  sq;
	logic [MANTW:0]      sq_top;
	logic signed [6:0]   ip;
	logic signed [26:0]  l2;
	logic [26:0]         mag;
	logic [57:0]         mprod;
	logic [58:0]         rnd;
	logic [LNW-1:0]      r;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			LG_IDLE: if (req.start) state_d = LG_NORM;
			LG_NORM: if (n_q[SW-1:SW-8] != '0 && n_q[SW-1]) state_d = LG_SQ;
			LG_SQ:   if (b_q == '0) state_d = LG_MUL;
			LG_MUL:  state_d = LG_RND;
			LG_RND:  state_d = LG_IDLE;
			default: state_d = LG_IDLE;
		endcase
	end

	// Squaring step, integer part, and scaling by ln 2.
	assign sq     = m_q * m_q;
	assign sq_top = sq[2*MANTW-1:MANTW-1];
	assign ip     = $signed({1'b0, p_q}) - $signed({1'b0, f_q});
	assign l2     = {ip, frac_q};
	assign mag    = l2[26] ? 27'(-l2) : 27'(l2);
	assign mprod  = mag[25:0] * LN2_Q32;
	assign rnd    = {1'b0, prod_q} + (59'd1 << 35);
	assign r      = {1'b0, rnd[58:36]};

	// Outputs.
	always_comb begin
		rsp.done = (state_q == LG_RND);
		rsp.ln   = neg_q ? $signed(-r) : $signed(r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath: normalise by eight bits or one bit a cycle, then one squaring step a cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			LG_IDLE: begin
				n_q <= req.x;
				f_q <= req.f;
				p_q <= 6'(SW - 1);
			end
			LG_NORM: begin
				if (n_q[SW-1:SW-8] == '0) begin
					n_q <= n_q << 8;
					p_q <= p_q - 6'd8;
				end else if (!n_q[SW-1]) begin
					n_q <= n_q << 1;
					p_q <= p_q - 6'd1;
				end else begin
					m_q    <= n_q[SW-1:SW-MANTW];
					frac_q <= '0;
					b_q    <= 5'(FRACW - 1);
				end
			end
			LG_SQ: begin
				if (sq_top[MANTW]) begin
					m_q         <= sq_top[MANTW:1];
					frac_q[b_q] <= 1'b1;
				end else begin
					m_q <= sq_top[MANTW-1:0];
				end
				b_q <= b_q - 5'd1;
			end
			LG_MUL: begin
				prod_q <= mprod;
				neg_q  <= l2[26];
			end
			default: begin
			end
		endcase
	end

endmodule

[design/hmm_scaled_forward_step_unit.sv]
// Channel  Role    Words carried
// step     sink    seq_start, emis_0..emis_3
// result   source  alpha_0..3, log_alpha_0..3, zero_sum_error
// wr_*     config  num_states, initial_dist, trans_row0..3
//
// One step runs a matrix-vector loop (a multiply and an add state per product), then, if the
// sum is non-zero, per used state a bit-serial divider of 16 quotient bits and a log unit of
// normalising, squaring and scaling steps per call (one call for the sum, one per non-zero
// alpha). A new step is taken only in idle; a finished result waits in the output register
// while the next step runs, and a step holds in its last state while the previous word is
// unaccepted. Reset clears the state, configuration and recurrence; num_states resets to 2.
`include "hmm_scaled_forward_step_unit_defines.svh"

module hmm_scaled_forward_step_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	hsf_step_if.sink              step,
	hsf_result_if.source          result,
	input  logic                  wr_en,
	input  logic [2:0]            wr_index,
	input  logic [hsf_pkg::REGW-1:0] wr_data
);
	import hsf_pkg::*;

	hsf_state_t            state_q, state_d;

	logic [2:0]            num_states_q;
	logic [REGW-1:0]       init_q;
	logic [REGW-1:0]       trans_q [MAX_STATES];
	logic [PW-1:0]         prev_q [MAX_STATES];
	logic signed [OW-1:0]  acc_q;

	logic [2:0]            m_q;
	logic                  start_q;
	logic [PW-1:0]         emis_q [MAX_STATES];
	logic [2:0]            lane_q;
	logic [2:0]            k_q;
	logic [TW-1:0]         t_q;
	logic [PRODW-1:0]      prod_q;
	logic [UW-1:0]         u_q [MAX_STATES];
	logic [SW-1:0]         sum_q;
	logic                  err_q;
	logic signed [OW-1:0]  acc_new_q;
	logic [SW-1:0]         rem_q;
	logic [PW-1:0]         nlo_q;
	logic [PW-1:0]         quo_q;
	logic [3:0]            dcnt_q;
	logic [PW-1:0]         alpha_q [MAX_STATES];
	logic signed [OW-1:0]  la_q [MAX_STATES];

	logic                  out_valid_q;
	logic [PW-1:0]         out_alpha_q [MAX_STATES];
	logic signed [OW-1:0]  out_la_q [MAX_STATES];
	logic                  out_err_q;

	lg_req_t               lg_req;
	lg_rsp_t               lg_rsp;

	logic [1:0]            li;
	logic [2:0]            m_in;
	logic                  out_free;
	logic [31:0]           pp;
	logic [PRODW-1:0]      pe;
	logic [63:0]           num;
	logic [51:0]           diff;
	logic signed [OW:0]    base_sum;
	logic signed [OW:0]    la_sum;
	logic signed [OW:0]    ln_ext;

	assign li       = lane_q[1:0];
	assign out_free = !out_valid_q || result.ready;
	assign m_in     = (num_states_q == 3'd0) ? 3'd1 :
		(num_states_q > 3'(MAX_STATES)) ? 3'(MAX_STATES) : num_states_q;

	// Shared arithmetic of the sequencer.
	assign pp       = prev_q[k_q[1:0]] * lane_of(trans_q[k_q[1:0]], li);
	assign pe       = t_q * emis_q[li];
	assign num      = {1'b0, u_q[li], 15'b0} + {15'b0, sum_q[SW-1:1]};
	assign diff     = {1'b0, rem_q, nlo_q[PW-1]} - {2'b0, sum_q};
	assign ln_ext   = {{(OW+1-LNW){lg_rsp.ln[LNW-1]}}, lg_rsp.ln};
	assign base_sum = (start_q ? $signed({(OW+1){1'b0}}) : $signed({acc_q[OW-1], acc_q}))
		+ ln_ext;
	assign la_sum   = $signed({acc_new_q[OW-1], acc_new_q}) + ln_ext;

	hsf_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lg_req),
		.rsp    (lg_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (step.valid) state_d = ST_LANE;
			ST_LANE: begin
				if (lane_q >= m_q) state_d = ST_CHECK;
				else if (start_q) state_d = ST_MUL_E;
				else state_d = ST_MUL_A;
			end
			ST_MUL_A:    state_d = ST_ADD;
			ST_ADD:      state_d = (k_q + 3'd1 == m_q) ? ST_MUL_E : ST_MUL_A;
			ST_MUL_E:    state_d = ST_STORE;
			ST_STORE:    state_d = ST_LANE;
			ST_CHECK:    state_d = (sum_q == '0) ? ST_OUT : ST_LOG_S;
			ST_LOG_S:    state_d = ST_WAIT_S;
			ST_WAIT_S:   if (lg_rsp.done) state_d = ST_DLANE;
			ST_DLANE: begin
				if (lane_q == 3'(MAX_STATES)) state_d = ST_OUT;
				else if (lane_q < m_q) state_d = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: state_d = ST_DIV_STEP;
			ST_DIV_STEP: if (dcnt_q == 4'd15) state_d = ST_ALPHA;
			ST_ALPHA:    state_d = (quo_q == '0) ? ST_DLANE : ST_LOG_A;
			ST_LOG_A:    state_d = ST_WAIT_A;
			ST_WAIT_A:   if (lg_rsp.done) state_d = ST_DLANE;
			ST_OUT:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		step.ready   = (state_q == ST_IDLE);
		lg_req.start = (state_q == ST_LOG_S) || (state_q == ST_LOG_A);
		lg_req.x     = (state_q == ST_LOG_S) ? sum_q : {{(SW-PW){1'b0}}, quo_q};
		lg_req.f     = (state_q == ST_LOG_S) ? F_SUM : F_ALPHA;
	end

	// Result word.
	always_comb begin
		result.valid          = out_valid_q;
		result.alpha_0        = out_alpha_q[0];
		result.alpha_1        = out_alpha_q[1];
		result.alpha_2        = out_alpha_q[2];
		result.alpha_3        = out_alpha_q[3];
		result.log_alpha_0    = out_la_q[0];
		result.log_alpha_1    = out_la_q[1];
		result.log_alpha_2    = out_la_q[2];
		result.log_alpha_3    = out_la_q[3];
		result.zero_sum_error = out_err_q;
	end

	// Control state, configuration and recurrence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			num_states_q <= 3'd2;
			init_q       <= '0;
			acc_q        <= '0;
			for (int i = 0; i < MAX_STATES; i++) begin
				trans_q[i] <= '0;
				prev_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				if (wr_index == CFG_NUM_STATES) begin
					num_states_q <= wr_data[2:0];
				end else if (wr_index == CFG_INIT_DIST) begin
					init_q <= wr_data;
				end else if (wr_index inside {[CFG_TRANS_ROW0:CFG_TRANS_ROW3]}) begin
					trans_q[2'(wr_index - CFG_TRANS_ROW0)] <= wr_data;
				end
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				if (!err_q) begin
					acc_q <= acc_new_q;
					for (int i = 0; i < MAX_STATES; i++) begin
						prev_q[i] <= alpha_q[i];
					end
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				start_q   <= step.seq_start;
				m_q       <= m_in;
				emis_q[0] <= clamp_prob(step.emis_0);
				emis_q[1] <= clamp_prob(step.emis_1);
				emis_q[2] <= clamp_prob(step.emis_2);
				emis_q[3] <= clamp_prob(step.emis_3);
				lane_q    <= '0;
				sum_q     <= '0;
				for (int i = 0; i < MAX_STATES; i++) begin
					u_q[i] <= '0;
				end
			end
			ST_LANE: begin
				t_q <= start_q ? {{(TW-PW){1'b0}}, lane_of(init_q, li)} : '0;
				k_q <= '0;
			end
			ST_MUL_A: prod_q <= {{(PRODW-32){1'b0}}, pp};
			ST_ADD: begin
				t_q <= t_q + prod_q[TW-1:0];
				k_q <= k_q + 3'd1;
			end
			ST_MUL_E: prod_q <= pe;
			ST_STORE: begin
				u_q[li] <= start_q ? {prod_q[UW-1-PROB_FRAC_BITS:0], {PROB_FRAC_BITS{1'b0}}}
					: prod_q[UW-1:0];
				sum_q   <= sum_q + (start_q
					? {{(SW-UW){1'b0}}, prod_q[UW-1-PROB_FRAC_BITS:0], {PROB_FRAC_BITS{1'b0}}}
					: {{(SW-UW){1'b0}}, prod_q[UW-1:0]});
				lane_q  <= lane_q + 3'd1;
			end
			ST_CHECK: begin
				err_q  <= (sum_q == '0);
				lane_q <= '0;
			end
			ST_WAIT_S: if (lg_rsp.done) acc_new_q <= sat48(base_sum);
			ST_DLANE: begin
				if (lane_q < 3'(MAX_STATES) && lane_q >= m_q) begin
					alpha_q[li] <= '0;
					la_q[li]    <= '0;
					lane_q      <= lane_q + 3'd1;
				end
			end
			ST_DIV_LOAD: begin
				rem_q  <= {2'b0, num[63:16]};
				nlo_q  <= num[15:0];
				dcnt_q <= '0;
			end
			// One quotient bit per cycle, restoring.
			ST_DIV_STEP: begin
				rem_q  <= diff[51] ? {rem_q[SW-2:0], nlo_q[PW-1]} : diff[SW-1:0];
				quo_q  <= {quo_q[PW-2:0], !diff[51]};
				nlo_q  <= nlo_q << 1;
				dcnt_q <= dcnt_q + 4'd1;
			end
			ST_ALPHA: begin
				alpha_q[li] <= quo_q;
				if (quo_q == '0) begin
					la_q[li] <= LOG_MIN;
					lane_q   <= lane_q + 3'd1;
				end
			end
			ST_WAIT_A: begin
				if (lg_rsp.done) begin
					la_q[li] <= sat48(la_sum);
					lane_q   <= lane_q + 3'd1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_err_q <= err_q;
					for (int i = 0; i < MAX_STATES; i++) begin
						out_alpha_q[i] <= err_q ? '0 : alpha_q[i];
						out_la_q[i]    <= err_q ? '0 : la_q[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	`HSF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, step.valid && step.ready, !step.ready)
	`HSF_ASSERT_IMPL(a_err_zero_fields, clk, arst_n, result.valid && result.zero_sum_error,
		result.alpha_0 == '0 && result.alpha_1 == '0 && result.log_alpha_0 == '0)
	`HSF_ASSERT_IMPL(a_log_done_waited, clk, arst_n, lg_rsp.done,
		state_q == ST_WAIT_S || state_q == ST_WAIT_A)

endmodule
